/* rtl/core/huffman_bit_packer_defines.svh */
// ----------------------------------------------------------------------------
// huffman_bit_packer_defines
// Assertion macros used by the bit packer checker.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define HBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define HBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hbp_pkg.sv */
// ----------------------------------------------------------------------------
// hbp_pkg
// Types, widths and codes of the Huffman bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

  localparam int unsigned ReqTypeW      = 2;
  localparam int unsigned SymbolW       = 8;
  localparam int unsigned CodeLenW      = 5;
  localparam int unsigned CodeWordW     = 20;
  localparam int unsigned OutByteW      = 8;
  localparam int unsigned ValidBitsW    = 4;
  localparam int unsigned TotalW        = 32;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned ByteShift     = 3;
  localparam int unsigned PendW         = 7;
  localparam int unsigned PendCntW      = 3;

  localparam int unsigned SymbolCountDef = 256;
  localparam int unsigned MaxCodeLenDef  = 20;
  localparam int unsigned QueueDepthDef  = 2;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_type_e;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef struct packed {
    logic [ReqTypeW-1:0]  req_type;
    logic [SymbolW-1:0]   symbol;
    logic [CodeLenW-1:0]  code_len;
    logic [CodeWordW-1:0] code_word;
  } req_t;

  typedef struct packed {
    logic [OutByteW-1:0]   out_byte;
    logic [ValidBitsW-1:0] valid_bits;
    logic                  last;
    logic [TotalW-1:0]     total_bits;
  } res_t;

  typedef struct packed {
    op_e                  op;
    logic [CodeLenW-1:0]  len;
    logic [CodeWordW-1:0] bits;
  } job_t;

  function automatic int unsigned len_cap(input int unsigned max_len);
    return (max_len < CodeWordW) ? max_len : CodeWordW;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hbp_stream_if.sv */
// ----------------------------------------------------------------------------
// hbp_stream_if
// Valid/ready channel carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbp_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* rtl/core/hbp_ram.sv */
// ----------------------------------------------------------------------------
// hbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/hbp_front.sv */
// ----------------------------------------------------------------------------
// hbp_front
// Request decode, code table writes and lookups, job issue to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_front #(
  parameter int unsigned SYMBOL_COUNT = hbp_pkg::SymbolCountDef,
  parameter int unsigned MAX_CODE_LEN = hbp_pkg::MaxCodeLenDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  hbp_stream_if.sink         req_i,
  output logic               job_vld_o,
  output hbp_pkg::job_t      job_o,
  input  wire logic          job_full_i
);

  import hbp_pkg::*;

  localparam int unsigned LenCap = len_cap(MAX_CODE_LEN);
  localparam int unsigned LenW   = $clog2(LenCap + 1);
  localparam int unsigned EntW   = LenW + LenCap;
  localparam int unsigned IdxW   = $clog2(SYMBOL_COUNT);

  req_t              req;
  logic              accept;
  logic              in_range;
  logic [IdxW-1:0]   sym_idx;
  logic              is_load;
  logic              is_enc;
  logic              is_flush;
  logic [LenW-1:0]   len_sat;
  logic [LenCap-1:0] code_msk;
  logic [LenCap-1:0] code_sat;
  logic              tbl_we;
  logic [EntW-1:0]   tbl_rdata;
  logic              push;

  logic [SYMBOL_COUNT-1:0] tbl_vld_q;
  logic                    s1_vld_q, s1_vld_d;
  op_e                     s1_op_q, s1_op_d;
  logic                    s1_hit_q, s1_hit_d;

  assign req      = req_i.payload;
  assign push     = s1_vld_q && !job_full_i;
  assign req_i.ready = !s1_vld_q || !job_full_i;
  assign accept   = req_i.valid && req_i.ready;
  assign in_range = {1'b0, req.symbol} < (SymbolW + 1)'(SYMBOL_COUNT);
  assign sym_idx  = req.symbol[IdxW-1:0];

  always_comb begin
    is_load  = 1'b0;
    is_enc   = 1'b0;
    is_flush = 1'b0;
    unique case (req.req_type)
      REQ_LOAD:   is_load  = accept;
      REQ_ENCODE: is_enc   = accept;
      REQ_FLUSH:  is_flush = accept;
      default:    ;
    endcase
  end

  always_comb begin
    if (req.code_len > CodeLenW'(LenCap)) begin
      len_sat = LenW'(LenCap);
    end else begin
      len_sat = LenW'(req.code_len);
    end
    for (int i = 0; i < LenCap; i++) begin
      code_msk[i] = (i < int'(len_sat));
    end
    code_sat = req.code_word[LenCap-1:0] & code_msk;
  end

  assign tbl_we = is_load && in_range;

  hbp_ram #(
    .WIDTH (EntW),
    .DEPTH (SYMBOL_COUNT)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (sym_idx),
    .wdata_i ({len_sat, code_sat}),
    .re_i    (is_enc),
    .raddr_i (sym_idx),
    .rdata_o (tbl_rdata)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    s1_op_d  = s1_op_q;
    s1_hit_d = s1_hit_q;
    if (is_enc || is_flush) begin
      s1_vld_d = 1'b1;
      s1_op_d  = is_flush ? OP_FLUSH : OP_ENCODE;
      s1_hit_d = is_enc && in_range && tbl_vld_q[sym_idx];
    end else if (push) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
      s1_vld_q  <= 1'b0;
      s1_op_q   <= OP_ENCODE;
      s1_hit_q  <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_q[sym_idx] <= 1'b1;
      end
      s1_vld_q <= s1_vld_d;
      s1_op_q  <= s1_op_d;
      s1_hit_q <= s1_hit_d;
    end
  end

  assign job_vld_o = push;

  always_comb begin
    job_o.op   = s1_op_q;
    job_o.len  = s1_hit_q ? CodeLenW'(tbl_rdata[EntW-1 -: LenW]) : '0;
    job_o.bits = s1_hit_q ? CodeWordW'(tbl_rdata[LenCap-1:0]) : '0;
  end

endmodule

`default_nettype wire

/* rtl/core/hbp_queue.sv */
// ----------------------------------------------------------------------------
// hbp_queue
// Short job queue between the front end and the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_queue #(
  parameter int unsigned DEPTH = hbp_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire hbp_pkg::job_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               vld_o,
  output hbp_pkg::job_t      data_o
);

  import hbp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hbp_back.sv */
// ----------------------------------------------------------------------------
// hbp_back
// Bit packer: appends codes to the pending byte and emits one byte a cycle while res_o is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_back #(
  parameter int unsigned MAX_CODE_LEN = hbp_pkg::MaxCodeLenDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_vld_i,
  input  wire hbp_pkg::job_t job_i,
  output logic               job_pop_o,
  hbp_stream_if.source       res_o
);

  import hbp_pkg::*;

  localparam int unsigned LenCap   = len_cap(MAX_CODE_LEN);
  localparam int unsigned AccW     = PendW + LenCap;
  localparam int unsigned CntW     = $clog2(AccW + 1);
  localparam int unsigned MaxBytes = AccW / ByteW;
  localparam int unsigned RemW     = $clog2(MaxBytes + 1);

  logic [PendW-1:0]      pend_bits_q;
  logic [PendCntW-1:0]   pend_cnt_q;
  logic [TotalW-1:0]     total_q;
  logic [AccW-1:0]       acc_q;
  logic [RemW-1:0]       rem_q;
  logic [ValidBitsW-1:0] res_vbits_q;
  logic [TotalW-1:0]     res_total_q;
  logic                  out_vld_q;
  res_t                  out_q;

  logic                  emit;
  logic                  pop;
  logic [AccW-1:0]       enc_acc;
  logic [CntW-1:0]       enc_cnt;
  logic [RemW-1:0]       enc_nb;
  logic [AccW-1:0]       enc_rest;
  logic [TotalW:0]       enc_sum;
  logic [TotalW-1:0]     enc_total;
  logic [PendW-1:0]      pend_msk;

  assign emit      = (rem_q != '0) && (!out_vld_q || res_o.ready);
  assign pop       = job_vld_i && ((rem_q == '0) || ((rem_q == RemW'(1)) && emit));
  assign job_pop_o = pop;

  always_comb begin
    enc_acc   = AccW'(pend_bits_q) | (AccW'(job_i.bits[LenCap-1:0]) << pend_cnt_q);
    enc_cnt   = CntW'(pend_cnt_q) + CntW'(job_i.len);
    enc_nb    = RemW'(enc_cnt >> ByteShift);
    enc_rest  = enc_acc >> {enc_nb, ByteShift'(0)};
    enc_sum   = {1'b0, total_q} + (TotalW + 1)'(job_i.len);
    enc_total = enc_sum[TotalW] ? '1 : enc_sum[TotalW-1:0];
    for (int i = 0; i < PendW; i++) begin
      pend_msk[i] = (i < int'(pend_cnt_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      total_q     <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      res_vbits_q <= '0;
      res_total_q <= '0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      if (pop) begin
        unique case (job_i.op)
          OP_ENCODE: begin
            acc_q       <= enc_acc;
            rem_q       <= enc_nb;
            res_vbits_q <= ValidBitsW'(ByteW);
            res_total_q <= enc_total;
            total_q     <= enc_total;
            pend_bits_q <= enc_rest[PendW-1:0];
            pend_cnt_q  <= enc_cnt[PendCntW-1:0];
          end
          OP_FLUSH: begin
            acc_q       <= AccW'(pend_bits_q & pend_msk);
            rem_q       <= RemW'(1);
            res_vbits_q <= ValidBitsW'(pend_cnt_q);
            res_total_q <= total_q;
            total_q     <= '0;
            pend_bits_q <= '0;
            pend_cnt_q  <= '0;
          end
        endcase
      end else if (emit) begin
        acc_q <= acc_q >> ByteW;
        rem_q <= rem_q - RemW'(1);
      end

      if (emit) begin
        out_vld_q        <= 1'b1;
        out_q.out_byte   <= acc_q[OutByteW-1:0];
        out_q.valid_bits <= res_vbits_q;
        out_q.last       <= (rem_q == RemW'(1));
        out_q.total_bits <= res_total_q;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

endmodule

`default_nettype wire

/* rtl/core/huffman_bit_packer.sv */
// ----------------------------------------------------------------------------
// huffman_bit_packer
// Path: the first result of an encode or flush passes the front-end stage
// register, the job queue, the packer accumulator and the output register;
// further bytes of one request follow one per cycle while res_o is ready.
// Throughput: one request a cycle while the job queue has room; loads never
// reach the packer. Reset clears it and marks every table entry unloaded.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_bit_packer #(
  parameter int unsigned SYMBOL_COUNT = hbp_pkg::SymbolCountDef,
  parameter int unsigned MAX_CODE_LEN = hbp_pkg::MaxCodeLenDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  hbp_stream_if.sink   req_i,
  hbp_stream_if.source res_o
);

  import hbp_pkg::*;

  job_t q_in;
  job_t q_out;
  logic q_push;
  logic q_full;
  logic q_vld;
  logic q_pop;

  hbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .job_vld_o  (q_push),
    .job_o      (q_in),
    .job_full_i (q_full)
  );

  hbp_queue #(
    .DEPTH (QueueDepthDef)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .data_o (q_out)
  );

  hbp_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_vld_i (q_vld),
    .job_i     (q_out),
    .job_pop_o (q_pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

/* rtl/core/hbp_checker.sv */
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks on the result channel of the bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_bit_packer_defines.svh"

module hbp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic [7:0]  res_out_byte_i,
  input wire logic [3:0]  res_valid_bits_i,
  input wire logic        res_last_i,
  input wire logic [31:0] res_total_bits_i
);

  import hbp_pkg::*;

  `HBP_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i, "result dropped")
  `HBP_ASSERT_NEXT(a_res_stable, res_valid_i && !res_ready_i, $stable(res_out_byte_i) && $stable(res_total_bits_i), "result changed while stalled")
  `HBP_ASSERT_IMPL(a_partial_last, res_valid_i && (res_valid_bits_i != ValidBitsW'(ByteW)), res_last_i, "partial byte not last")
  `HBP_ASSERT_NEXT(a_total_same, res_valid_i && res_ready_i && !res_last_i, res_valid_i && (res_total_bits_i == $past(res_total_bits_i)), "bytes of one request split")

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_out_byte_i   (res_o.payload.out_byte),
  .res_valid_bits_i (res_o.payload.valid_bits),
  .res_last_i       (res_o.payload.last),
  .res_total_bits_i (res_o.payload.total_bits)
);

`default_nettype wire
